// ----- hw/rtl/dedup_pair_stack_with_bulk_delete_assert.svh -----
`ifndef DEDUP_PAIR_STACK_WITH_BULK_DELETE_ASSERT_SVH
`define DEDUP_PAIR_STACK_WITH_BULK_DELETE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/dps_pkg.sv -----
`default_nettype none

package dps_pkg;

    localparam int DEPTH = 128;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = 64;

    localparam logic [1:0] OP_ADD       = 2'd0;
    localparam logic [1:0] OP_POP       = 2'd1;
    localparam logic [1:0] OP_DEL_TABLE = 2'd2;
    localparam logic [1:0] OP_DEL_PAIR  = 2'd3;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_DUP   = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    localparam logic [1:0] SEL_NEXT = 2'd0;
    localparam logic [1:0] SEL_HEAD = 2'd1;
    localparam logic [1:0] SEL_KEY  = 2'd2;

    typedef struct packed {
        logic       we;
        logic [1:0] sel;
    } cell_ctrl_t;

    typedef struct packed {
        logic             step;
        logic             keep;
        logic             append;
        logic [IDX_W-1:0] tail_idx;
        logic [IDX_W-1:0] app_idx;
    } pass_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dedup_pair_stack_with_bulk_delete.sv -----
// Deduplicating stack of (table, index) key pairs with bulk delete.
// Input channel: in_valid / in_stall with operation, table_key, index_key.
// Output channel: out_valid / out_stall with popped_table, popped_index,
// status, removed_count and occupancy; exactly one result per item.
// The store is a row of cells; cell 0 is the oldest entry and feeds a head
// bus. Every operation runs one pass over the held entries, one entry per
// cycle: each cycle the row shifts toward cell 0 and the head re-enters at
// the end of the live region unless it is dropped, so order is kept.
// An item is accepted in idle, then scans the N entries held when it is
// accepted (at most 128), then waits in a finish state until its result is
// loaded into the output register. The pass length is set by the entry count.
// in_stall is high while a pass runs and while a finished result cannot be
// loaded because the previous result is still stalled at the output.
// A stalled result holds in the output register; the next item is taken
// meanwhile and waits at the end of its pass.
// Reset empties the store at once; entry contents are not cleared.
`default_nettype none

module dedup_pair_stack_with_bulk_delete
    import dps_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [1:0]       operation,
    input  wire logic [KEY_W-1:0] table_key,
    input  wire logic [KEY_W-1:0] index_key,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic      [KEY_W-1:0] popped_table,
    output logic      [KEY_W-1:0] popped_index,
    output logic      [1:0]       status,
    output logic      [7:0]       removed_count,
    output logic      [7:0]       occupancy
);

    pass_ctrl_t       pass;
    logic [KEY_W-1:0] key_table;
    logic [KEY_W-1:0] key_index;
    logic [KEY_W-1:0] cell_table [DEPTH];
    logic [KEY_W-1:0] cell_index [DEPTH];
    cell_ctrl_t       cell_ctrl  [DEPTH];

    dps_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .table_key     (table_key),
        .index_key     (index_key),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .popped_table  (popped_table),
        .popped_index  (popped_index),
        .status        (status),
        .removed_count (removed_count),
        .occupancy     (occupancy),
        .head_table    (cell_table[0]),
        .head_index    (cell_index[0]),
        .key_table     (key_table),
        .key_index     (key_index),
        .pass          (pass)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_W-1:0] nxt_table;
        logic [KEY_W-1:0] nxt_index;

        if (i == DEPTH - 1)
        begin : g_last
            assign nxt_table = cell_table[0];
            assign nxt_index = cell_index[0];
        end
        else
        begin : g_mid
            assign nxt_table = cell_table[i+1];
            assign nxt_index = cell_index[i+1];
        end

        always_comb
        begin
            cell_ctrl[i].we  = pass.step || (pass.append && (pass.app_idx == IDX_W'(i)));
            cell_ctrl[i].sel = SEL_NEXT;
            if (pass.append)
            begin
                cell_ctrl[i].sel = SEL_KEY;
            end
            else if (pass.keep && (pass.tail_idx == IDX_W'(i)))
            begin
                cell_ctrl[i].sel = SEL_HEAD;
            end
        end

        dps_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[i]),
            .next_table (nxt_table),
            .next_index (nxt_index),
            .head_table (cell_table[0]),
            .head_index (cell_index[0]),
            .key_table  (key_table),
            .key_index  (key_index),
            .table_q    (cell_table[i]),
            .index_q    (cell_index[i])
        );
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dps_cell.sv -----
`default_nettype none

module dps_cell
    import dps_pkg::*;
(
    input  wire logic             clk,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic [KEY_W-1:0] next_table,
    input  wire logic [KEY_W-1:0] next_index,
    input  wire logic [KEY_W-1:0] head_table,
    input  wire logic [KEY_W-1:0] head_index,
    input  wire logic [KEY_W-1:0] key_table,
    input  wire logic [KEY_W-1:0] key_index,
    output logic      [KEY_W-1:0] table_q,
    output logic      [KEY_W-1:0] index_q
);

    logic [KEY_W-1:0] table_reg;
    logic [KEY_W-1:0] index_reg;
    logic [KEY_W-1:0] table_next;
    logic [KEY_W-1:0] index_next;

    always_comb
    begin
        case (ctrl.sel)
            SEL_HEAD:
            begin
                table_next = head_table;
                index_next = head_index;
            end
            SEL_KEY:
            begin
                table_next = key_table;
                index_next = key_index;
            end
            default:
            begin
                table_next = next_table;
                index_next = next_index;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.we)
        begin
            table_reg <= table_next;
            index_reg <= index_next;
        end
    end

    assign table_q = table_reg;
    assign index_q = index_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/dps_ctrl.sv -----
`default_nettype none

`include "dedup_pair_stack_with_bulk_delete_assert.svh"

module dps_ctrl
    import dps_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [1:0]       operation,
    input  wire logic [KEY_W-1:0] table_key,
    input  wire logic [KEY_W-1:0] index_key,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic      [KEY_W-1:0] popped_table,
    output logic      [KEY_W-1:0] popped_index,
    output logic      [1:0]       status,
    output logic      [7:0]       removed_count,
    output logic      [7:0]       occupancy,
    input  wire logic [KEY_W-1:0] head_table,
    input  wire logic [KEY_W-1:0] head_index,
    output logic      [KEY_W-1:0] key_table,
    output logic      [KEY_W-1:0] key_index,
    output pass_ctrl_t            pass
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]       state_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] start_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [1:0]       op_reg;
    logic [KEY_W-1:0] tkey_reg;
    logic [KEY_W-1:0] ikey_reg;
    logic             dup_reg;
    logic             hit_reg;
    logic [KEY_W-1:0] ptab_reg;
    logic [KEY_W-1:0] pidx_reg;

    logic             out_valid_reg;
    logic [KEY_W-1:0] out_table_reg;
    logic [KEY_W-1:0] out_index_reg;
    logic [1:0]       out_status_reg;
    logic [7:0]       out_removed_reg;
    logic [7:0]       out_occ_reg;

    logic             tab_eq;
    logic             pair_eq;
    logic             step;
    logic             drop;
    logic             finish;
    logic             append;
    logic             full;
    logic [1:0]       status_next;
    logic [7:0]       removed_next;
    logic [CNT_W-1:0] count_next;

    assign tab_eq  = (head_table == tkey_reg);
    assign pair_eq = tab_eq && (head_index == ikey_reg);
    assign step    = (state_reg == ST_SCAN) && (rem_reg != '0);
    assign finish  = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign append  = finish && (op_reg == OP_ADD) && !dup_reg && !full;

    always_comb
    begin
        unique case (op_reg)
            OP_ADD:       drop = 1'b0;
            OP_POP:       drop = (rem_reg == CNT_W'(1));
            OP_DEL_TABLE: drop = tab_eq;
            OP_DEL_PAIR:  drop = !hit_reg && pair_eq;
            default:      drop = 1'b0;
        endcase
    end

    always_comb
    begin
        status_next  = STAT_DONE;
        removed_next = 8'(start_reg - count_reg);
        unique case (op_reg)
            OP_ADD:
            begin
                removed_next = '0;
                if (dup_reg)
                begin
                    status_next = STAT_DUP;
                end
                else if (full)
                begin
                    status_next = STAT_FULL;
                end
            end
            OP_POP:
            begin
                removed_next = '0;
                if (start_reg == '0)
                begin
                    status_next = STAT_EMPTY;
                end
            end
            default:
            begin
                status_next = STAT_DONE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (step && drop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else if (append)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        rem_reg   <= count_reg;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (rem_reg == '0)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        rem_reg <= rem_reg - CNT_W'(1);
                    end
                end
                ST_FIN:
                begin
                    if (finish)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && in_valid)
        begin
            op_reg    <= operation;
            tkey_reg  <= table_key;
            ikey_reg  <= index_key;
            start_reg <= count_reg;
            dup_reg   <= 1'b0;
            hit_reg   <= 1'b0;
            ptab_reg  <= '0;
            pidx_reg  <= '0;
        end
        else if (step)
        begin
            if ((op_reg == OP_ADD) && pair_eq)
            begin
                dup_reg <= 1'b1;
            end
            if (drop)
            begin
                hit_reg <= 1'b1;
            end
            if (drop && (op_reg == OP_POP))
            begin
                ptab_reg <= head_table;
                pidx_reg <= head_index;
            end
        end
        if (finish)
        begin
            out_table_reg   <= ptab_reg;
            out_index_reg   <= pidx_reg;
            out_status_reg  <= status_next;
            out_removed_reg <= removed_next;
            out_occ_reg     <= 8'(count_next);
        end
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign popped_table  = out_table_reg;
    assign popped_index  = out_index_reg;
    assign status        = out_status_reg;
    assign removed_count = out_removed_reg;
    assign occupancy     = out_occ_reg;
    assign key_table     = tkey_reg;
    assign key_index     = ikey_reg;

    assign pass.step     = step;
    assign pass.keep     = !drop;
    assign pass.append   = append;
    assign pass.tail_idx = IDX_W'(count_reg - CNT_W'(1));
    assign pass.app_idx  = IDX_W'(count_reg);

    `DPS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "count above depth")
    `DPS_ASSERT_NOW(a_rem_bound, state_reg == ST_SCAN, rem_reg <= count_reg, "scan past region")
    `DPS_ASSERT_NEXT(a_drop_shrinks, step && drop, count_reg == $past(count_reg) - CNT_W'(1),
        "drop did not shrink store")
    `DPS_ASSERT_NEXT(a_finish_result, finish, out_valid && (occupancy == 8'($past(count_next))),
        "result not presented")

endmodule

`default_nettype wire
